/* design/clpf_pkg.sv */
// ----------------------------------------------------------------------------
// clpf_pkg
// Shared types, constants and saturating helpers for the pair force unit.
// ----------------------------------------------------------------------------
package clpf_pkg;

    // field widths
    localparam int IDX_W   = 12;
    localparam int COORD_W = 32;
    localparam int CHG_W   = 16;
    localparam int LJ_W    = 48;
    localparam int FRC_W   = 48;
    localparam int NRG_W   = 64;

    // close pair floor on the squared distance
    localparam logic [63:0] R_FLOOR  = 64'd1 << 30;
    // signed range limits
    localparam logic [63:0] I64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] I64_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [47:0] FRC_MAX  = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] FRC_MIN  = 48'h8000_0000_0000;
    // largest values that survive a scale by 12 and by 6
    localparam logic [63:0] CAP12    = 64'd768614336404564650;
    localparam logic [63:0] CAP6     = 64'd1537228672809129301;

    // operation of the shared divide / root unit
    typedef enum logic {
        RD_DIV,
        RD_SQRT
    } rd_mode_t;

    // value with its saturation flag
    typedef struct packed {
        logic        sat;
        logic [63:0] val;
    } sat64_t;

    // floor(p / 2^sh) saturated to the unsigned 64-bit top
    function automatic sat64_t mul_shift(input logic [127:0] p, input int sh);
        sat64_t      r;
        logic [127:0] t;
        t     = p >> sh;
        r.sat = (t[127:64] != 64'd0);
        r.val = r.sat ? {64{1'b1}} : t[63:0];
        return r;
    endfunction

    // signed 64-bit add saturated to the signed range
    function automatic sat64_t sadd64(input logic [63:0] a, input logic [63:0] b);
        sat64_t      r;
        logic [64:0] s;
        s     = {a[63], a} + {b[63], b};
        r.sat = (s[64] != s[63]);
        r.val = r.sat ? (s[64] ? I64_MIN : I64_MAX) : s[63:0];
        return r;
    endfunction

endpackage

/* design/clpf_mul.sv */
// ----------------------------------------------------------------------------
// clpf_mul
// 64 x 64 unsigned multiplier built from one 32 x 32 multiplier, its partial
// products summed into a 128-bit accumulator.
// ----------------------------------------------------------------------------
module clpf_mul (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic         done,
    output logic [127:0] prod
);

    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [127:0] acc_reg;
    logic [1:0]   step_reg;
    logic         busy_reg;
    logic         done_reg;
    logic [31:0]  a_sel;
    logic [31:0]  b_sel;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    // partial product for the current half pair
    always_comb
    begin
        a_sel = step_reg[1] ? a_reg[63:32] : a_reg[31:0];
        b_sel = step_reg[0] ? b_reg[63:32] : b_reg[31:0];
        pp    = a_sel * b_sel;
        unique case (step_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd1:    pp_sh = {32'd0, pp, 32'd0};
            2'd2:    pp_sh = {32'd0, pp, 32'd0};
            default: pp_sh = {pp, 64'd0};
        endcase
    end

    // operand capture
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
    end

    // accumulate sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            acc_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_reg + pp_sh;
            step_reg <= step_reg + 2'd1;
            if (step_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

/* design/clpf_rootdiv.sv */
// ----------------------------------------------------------------------------
// clpf_rootdiv
// Bit-serial restoring unit shared by the reciprocal floor(2^78 / r) and the
// root floor(sqrt(v * 2^40)); one quotient or root bit per cycle.
// ----------------------------------------------------------------------------
module clpf_rootdiv (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  clpf_pkg::rd_mode_t mode,
    input  logic [63:0]       operand,
    output logic              done,
    output logic [63:0]       result
);

    localparam logic [6:0] DIV_TOP  = 7'd78;
    localparam logic [6:0] ROOT_TOP = 7'd44;

    clpf_pkg::rd_mode_t mode_reg;
    logic [63:0] rem_reg;
    logic [63:0] q_reg;
    logic [63:0] den_reg;
    logic [89:0] src_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] shifted;
    logic [63:0] sub;
    logic        take;
    logic [63:0] rem_next;

    // one compare and subtract step
    always_comb
    begin
        unique case (mode_reg)
            clpf_pkg::RD_DIV:
            begin
                shifted = {rem_reg[62:0], (cnt_reg == DIV_TOP)};
                sub     = den_reg;
                take    = rem_reg[63] | (shifted >= sub);
            end
            default:
            begin
                shifted = {rem_reg[61:0], src_reg[89:88]};
                sub     = {q_reg[61:0], 2'b01};
                take    = (shifted >= sub);
            end
        endcase
        rem_next = take ? (shifted - sub) : shifted;
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= clpf_pkg::RD_DIV;
            rem_reg  <= '0;
            q_reg    <= '0;
            den_reg  <= '0;
            src_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            mode_reg <= mode;
            rem_reg  <= '0;
            q_reg    <= '0;
            den_reg  <= operand;
            src_reg  <= {operand[49:0], 40'd0};
            cnt_reg  <= (mode == clpf_pkg::RD_DIV) ? DIV_TOP : ROOT_TOP;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[62:0], take};
            src_reg <= {src_reg[87:0], 2'b00};
            cnt_reg <= cnt_reg - 7'd1;
            if (cnt_reg == 7'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done   = done_reg;
    assign result = q_reg;

endmodule

/* design/coulomb_lj_pair_force_unit.sv */
// ----------------------------------------------------------------------------
// coulomb_lj_pair_force_unit
// Coulomb plus 12-6 Lennard-Jones pair force engine with per-atom position
// and force stores, two energy totals and a saturation flag.
// ----------------------------------------------------------------------------
//  channel   signals                       direction  moves
//  s_*       s_tvalid s_tready s_tdata     in         one command
//            s_tuser
//  m_*       m_tvalid m_tready m_tdata     out        one result per command
//  cfg_*     cfg_valid cfg_ready cfg_data  in         coulomb_scale write
//
//  A pair runs the bit-serial reciprocal and root on the shared divide/root
//  unit and each 64 x 64 product on the single 32 x 32 multiplier; the van
//  der Waals term adds the r^6, r^12 and coefficient products.
//  After reset a clearing pass zeroes the force store, one entry per cycle
//  (MAX_ATOMS entries, at most 4096), with s_tready low.
//  One command at a time; a held result holds the next command in ST_DONE.
// ----------------------------------------------------------------------------
module coulomb_lj_pair_force_unit #(
    parameter int MAX_ATOMS = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // atom_a, atom_b, coord_x, coord_y, coord_z, charge_a, charge_b,
    // with_vdw, lj_repulsion, lj_dispersion, zero fill
    input  logic [255:0] s_tdata,
    // cmd
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // force_x, force_y, force_z, coulomb_energy, vdw_energy, saturated,
    // zero fill
    output logic [279:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);

    localparam int DEPTH = (MAX_ATOMS > (1 << clpf_pkg::IDX_W)) ?
                           (1 << clpf_pkg::IDX_W) : MAX_ATOMS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_PAIR   = 2'd1,
        CMD_READ   = 2'd2,
        CMD_ENERGY = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_LOAD, ST_READ_REQ, ST_READ_CAP,
        ST_RDA, ST_RDB, ST_DIFF, ST_SQ, ST_DIV, ST_SQRT,
        ST_QQ, ST_T1, ST_EC, ST_R4, ST_R6, ST_R12, ST_VA, ST_VB,
        ST_VDW, ST_DVA, ST_SCL, ST_FK, ST_FRA, ST_FUA, ST_FRB, ST_FUB,
        ST_TOT, ST_DONE
    } state_t;

    state_t      state_reg;
    cmd_t        cmd_reg;
    logic [31:0] scale_reg;
    logic [11:0] ia_reg;
    logic [11:0] ib_reg;
    logic [31:0] cx_reg;
    logic [31:0] cy_reg;
    logic [31:0] cz_reg;
    logic [15:0] qa_reg;
    logic [15:0] qb_reg;
    logic        vdw_reg;
    logic [47:0] lja_reg;
    logic [47:0] ljb_reg;

    logic [31:0] pa_reg [3];
    logic [31:0] m_reg [3];
    logic        dneg_reg [3];
    logic [47:0] delta_reg [3];
    logic [47:0] resf_reg [3];
    logic [63:0] r_reg;
    logic [63:0] r2_reg;
    logic [63:0] ri_reg;
    logic [30:0] qq_reg;
    logic [63:0] t1_reg;
    logic [63:0] ec_reg;
    logic [63:0] tmp_reg;
    logic [63:0] r6_reg;
    logic [63:0] r12_reg;
    logic [63:0] va_reg;
    logic [63:0] vb_reg;
    logic [63:0] c12_reg;
    logic [63:0] c6_reg;
    logic [63:0] evdw_reg;
    logic [63:0] dva_reg;
    logic [63:0] s_reg;
    logic [63:0] ct_reg;
    logic [63:0] vt_reg;
    logic        sat_reg;
    logic [1:0]  k_reg;
    logic        issued_reg;
    logic [AW-1:0] clr_reg;
    logic        m_tvalid_reg;
    logic [279:0] m_tdata_reg;

    logic [95:0]  pos_mem [DEPTH];
    logic [143:0] frc_mem [DEPTH];
    logic [95:0]  pos_rd_reg;
    logic [143:0] frc_rd_reg;

    logic          s_acc;
    logic          a_ok_in;
    logic          b_ok_in;
    logic [11:0]   s_ia;
    logic [11:0]   s_ib;
    logic [AW-1:0] pos_raddr;
    logic [AW-1:0] frc_raddr;
    logic          pos_we;
    logic          frc_we;
    logic [AW-1:0] frc_waddr;
    logic [143:0]  frc_wdata;
    logic [143:0]  fnew;
    logic          fsat;

    logic          mul_start;
    logic [63:0]   mul_a;
    logic [63:0]   mul_b;
    logic          mul_done;
    logic [127:0]  prod;
    logic          rd_start;
    clpf_pkg::rd_mode_t rd_mode;
    logic [63:0]   rd_operand;
    logic          rd_done;
    logic [63:0]   rd_result;

    clpf_pkg::sat64_t ms40;
    clpf_pkg::sat64_t ms32;
    clpf_pkg::sat64_t ms20;
    clpf_pkg::sat64_t dva_res;
    clpf_pkg::sat64_t ct_res;
    clpf_pkg::sat64_t vt_res;
    logic [63:0]   inner;
    logic [63:0]   ec_neg;
    logic [63:0]   dva_mag;
    logic [15:0]   qa_mag;
    logic [15:0]   qb_mag;
    logic [32:0]   dk [3];
    logic [47:0]   fcap;
    logic          fsat_k;

    // input handshake and index checks
    assign s_ia      = s_tdata[11:0];
    assign s_ib      = s_tdata[23:12];
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign a_ok_in   = ({20'd0, s_ia} < 32'(MAX_ATOMS));
    assign b_ok_in   = ({20'd0, s_ib} < 32'(MAX_ATOMS));
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // shared arithmetic units
    clpf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (prod)
    );

    clpf_rootdiv u_rootdiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (rd_start),
        .mode    (rd_mode),
        .operand (rd_operand),
        .done    (rd_done),
        .result  (rd_result)
    );

    // multiplier operand selection and start
    always_comb
    begin
        qa_mag = qa_reg[15] ? (16'd0 - qa_reg) : qa_reg;
        qb_mag = qb_reg[15] ? (16'd0 - qb_reg) : qb_reg;
        dva_mag = dva_reg[63] ? (64'd0 - dva_reg) : dva_reg;
        mul_a = '0;
        mul_b = '0;
        mul_start = 1'b0;
        unique case (state_reg)
            ST_SQ:   begin mul_a = {32'd0, m_reg[k_reg]}; mul_b = {32'd0, m_reg[k_reg]}; end
            ST_QQ:   begin mul_a = {48'd0, qa_mag};       mul_b = {48'd0, qb_mag};       end
            ST_T1:   begin mul_a = {33'd0, qq_reg};       mul_b = {32'd0, scale_reg};    end
            ST_EC:   begin mul_a = t1_reg;                mul_b = ri_reg;                end
            ST_R4:   begin mul_a = r2_reg;                mul_b = r2_reg;                end
            ST_R6:   begin mul_a = tmp_reg;               mul_b = r2_reg;                end
            ST_R12:  begin mul_a = r6_reg;                mul_b = r6_reg;                end
            ST_VA:   begin mul_a = {16'd0, lja_reg};      mul_b = r12_reg;               end
            ST_VB:   begin mul_a = {16'd0, ljb_reg};      mul_b = r6_reg;                end
            ST_SCL:  begin mul_a = dva_mag;               mul_b = r2_reg;                end
            ST_FK:   begin mul_a = s_reg;                 mul_b = {32'd0, m_reg[k_reg]}; end
            default: begin mul_a = '0;                    mul_b = '0;                    end
        endcase
        unique case (state_reg)
            ST_SQ, ST_QQ, ST_T1, ST_EC, ST_R4, ST_R6, ST_R12, ST_VA, ST_VB,
            ST_SCL, ST_FK: mul_start = !issued_reg;
            default:       mul_start = 1'b0;
        endcase
    end

    // divide / root unit control
    always_comb
    begin
        rd_mode    = (state_reg == ST_SQRT) ? clpf_pkg::RD_SQRT : clpf_pkg::RD_DIV;
        rd_operand = (state_reg == ST_SQRT) ? r2_reg :
                     ((r_reg < clpf_pkg::R_FLOOR) ? clpf_pkg::R_FLOOR : r_reg);
        rd_start   = ((state_reg == ST_DIV) || (state_reg == ST_SQRT)) && !issued_reg;
    end

    // product post-processing and energy sums
    always_comb
    begin
        ms40    = clpf_pkg::mul_shift(prod, 40);
        ms32    = clpf_pkg::mul_shift(prod, 32);
        ms20    = clpf_pkg::mul_shift(prod, 20);
        inner   = c12_reg - c6_reg;
        ec_neg  = 64'd0 - ec_reg;
        dva_res = clpf_pkg::sadd64(ec_neg, 64'd0 - inner);
        ct_res  = clpf_pkg::sadd64(ct_reg, ec_reg);
        vt_res  = clpf_pkg::sadd64(vt_reg, evdw_reg);
        fsat_k  = ms20.sat || (ms20.val > {16'd0, clpf_pkg::FRC_MAX});
        fcap    = fsat_k ? clpf_pkg::FRC_MAX : ms20.val[47:0];
        for (int k = 0; k < 3; k++)
        begin
            dk[k] = {pos_rd_reg[32*k+31], pos_rd_reg[32*k +: 32]}
                  - {pa_reg[k][31], pa_reg[k]};
        end
    end

    // force read-modify-write with clamping
    always_comb
    begin
        logic [47:0] old;
        logic [48:0] sum;
        fsat = 1'b0;
        fnew = '0;
        for (int k = 0; k < 3; k++)
        begin
            old = frc_rd_reg[48*k +: 48];
            if (state_reg == ST_FUB)
            begin
                sum = {old[47], old} + {delta_reg[k][47], delta_reg[k]};
            end
            else
            begin
                sum = {old[47], old} - {delta_reg[k][47], delta_reg[k]};
            end
            if (sum[48] != sum[47])
            begin
                fsat = 1'b1;
                fnew[48*k +: 48] = sum[48] ? clpf_pkg::FRC_MIN : clpf_pkg::FRC_MAX;
            end
            else
            begin
                fnew[48*k +: 48] = sum[47:0];
            end
        end
    end

    // memory addressing
    always_comb
    begin
        pos_raddr = (state_reg == ST_RDA) ? ia_reg[AW-1:0] : ib_reg[AW-1:0];
        frc_raddr = (state_reg == ST_FRB) ? ib_reg[AW-1:0] : ia_reg[AW-1:0];
        pos_we    = (state_reg == ST_LOAD);
        frc_we    = 1'b0;
        frc_waddr = ia_reg[AW-1:0];
        frc_wdata = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                frc_we    = 1'b1;
                frc_waddr = clr_reg;
            end
            ST_LOAD:
            begin
                frc_we = 1'b1;
            end
            ST_FUA:
            begin
                frc_we    = 1'b1;
                frc_wdata = fnew;
            end
            ST_FUB:
            begin
                frc_we    = 1'b1;
                frc_waddr = ib_reg[AW-1:0];
                frc_wdata = fnew;
            end
            default:
            begin
                frc_we = 1'b0;
            end
        endcase
    end

    // position store
    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_mem[ia_reg[AW-1:0]] <= {cz_reg, cy_reg, cx_reg};
        end
        pos_rd_reg <= pos_mem[pos_raddr];
    end

    // force store
    always_ff @(posedge clk)
    begin
        if (frc_we)
        begin
            frc_mem[frc_waddr] <= frc_wdata;
        end
        frc_rd_reg <= frc_mem[frc_raddr];
    end

    // command payload capture
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            ia_reg  <= s_ia;
            ib_reg  <= s_ib;
            cx_reg  <= s_tdata[55:24];
            cy_reg  <= s_tdata[87:56];
            cz_reg  <= s_tdata[119:88];
            qa_reg  <= s_tdata[135:120];
            qb_reg  <= s_tdata[151:136];
            vdw_reg <= s_tdata[152];
            lja_reg <= s_tdata[200:153];
            ljb_reg <= s_tdata[248:201];
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cmd_reg      <= CMD_LOAD;
            scale_reg    <= 32'd1392788733;
            clr_reg      <= '0;
            k_reg        <= '0;
            issued_reg   <= 1'b0;
            ct_reg       <= '0;
            vt_reg       <= '0;
            sat_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            r_reg        <= '0;
            for (int k = 0; k < 3; k++)
            begin
                resf_reg[k] <= '0;
            end
        end
        else
        begin
            // configuration write
            if (cfg_valid)
            begin
                scale_reg <= cfg_data;
            end

            // result register drains independently
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            // unit handshakes
            if (mul_start || rd_start)
            begin
                issued_reg <= 1'b1;
            end
            if (mul_done || rd_done)
            begin
                issued_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(DEPTH - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_acc)
                    begin
                        cmd_reg <= cmd_t'(s_tuser);
                        k_reg   <= '0;
                        r_reg   <= '0;
                        for (int k = 0; k < 3; k++)
                        begin
                            resf_reg[k] <= '0;
                        end
                        unique case (cmd_t'(s_tuser))
                            CMD_LOAD:   state_reg <= a_ok_in ? ST_LOAD : ST_DONE;
                            CMD_PAIR:   state_reg <= (a_ok_in && b_ok_in) ? ST_RDA : ST_DONE;
                            CMD_READ:   state_reg <= a_ok_in ? ST_READ_REQ : ST_DONE;
                            default:    state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_LOAD:     state_reg <= ST_DONE;
                ST_READ_REQ: state_reg <= ST_READ_CAP;
                ST_READ_CAP:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        resf_reg[k] <= frc_rd_reg[48*k +: 48];
                    end
                    state_reg <= ST_DONE;
                end
                ST_RDA:      state_reg <= ST_RDB;
                ST_RDB:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        pa_reg[k] <= pos_rd_reg[32*k +: 32];
                    end
                    state_reg <= ST_DIFF;
                end
                ST_DIFF:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        dneg_reg[k] <= dk[k][32];
                        m_reg[k]    <= dk[k][32] ? 32'(33'd0 - dk[k]) : dk[k][31:0];
                    end
                    state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    if (mul_done)
                    begin
                        r_reg <= r_reg + prod[65:2];
                        k_reg <= k_reg + 2'd1;
                        if (k_reg == 2'd2)
                        begin
                            k_reg     <= '0;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (rd_start && (r_reg < clpf_pkg::R_FLOOR))
                    begin
                        sat_reg <= 1'b1;
                    end
                    if (rd_done)
                    begin
                        r2_reg    <= rd_result;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT:
                begin
                    if (rd_done)
                    begin
                        ri_reg    <= rd_result;
                        state_reg <= ST_QQ;
                    end
                end
                ST_QQ:
                begin
                    if (mul_done)
                    begin
                        qq_reg    <= prod[30:0];
                        state_reg <= ST_T1;
                    end
                end
                ST_T1:
                begin
                    if (mul_done)
                    begin
                        t1_reg    <= prod[63:0];
                        state_reg <= ST_EC;
                    end
                end
                ST_EC:
                begin
                    if (mul_done)
                    begin
                        ec_reg    <= (qa_reg[15] ^ qb_reg[15]) ?
                                     (64'd0 - prod[127:64]) : prod[127:64];
                        state_reg <= vdw_reg ? ST_R4 : ST_VDW;
                    end
                end
                ST_R4:
                begin
                    if (mul_done)
                    begin
                        tmp_reg   <= ms40.val;
                        sat_reg   <= sat_reg | ms40.sat;
                        state_reg <= ST_R6;
                    end
                end
                ST_R6:
                begin
                    if (mul_done)
                    begin
                        r6_reg    <= ms40.val;
                        sat_reg   <= sat_reg | ms40.sat;
                        state_reg <= ST_R12;
                    end
                end
                ST_R12:
                begin
                    if (mul_done)
                    begin
                        r12_reg   <= ms40.val;
                        sat_reg   <= sat_reg | ms40.sat;
                        state_reg <= ST_VA;
                    end
                end
                ST_VA:
                begin
                    if (mul_done)
                    begin
                        va_reg    <= ms32.val[63] ? clpf_pkg::I64_MAX : ms32.val;
                        sat_reg   <= sat_reg | ms32.sat | ms32.val[63];
                        state_reg <= ST_VB;
                    end
                end
                ST_VB:
                begin
                    if (mul_done)
                    begin
                        vb_reg    <= ms32.val[63] ? clpf_pkg::I64_MAX : ms32.val;
                        sat_reg   <= sat_reg | ms32.sat | ms32.val[63];
                        state_reg <= ST_VDW;
                    end
                end
                ST_VDW:
                begin
                    // energy and scaled terms, zero without the vdw term
                    if (vdw_reg)
                    begin
                        evdw_reg <= va_reg - vb_reg;
                        c12_reg  <= (va_reg > clpf_pkg::CAP12) ? clpf_pkg::I64_MAX :
                                    ((va_reg << 3) + (va_reg << 2));
                        c6_reg   <= (vb_reg > clpf_pkg::CAP6) ? clpf_pkg::I64_MAX :
                                    ((vb_reg << 2) + (vb_reg << 1));
                        sat_reg  <= sat_reg | (va_reg > clpf_pkg::CAP12)
                                            | (vb_reg > clpf_pkg::CAP6);
                    end
                    else
                    begin
                        evdw_reg <= '0;
                        c12_reg  <= '0;
                        c6_reg   <= '0;
                    end
                    state_reg <= ST_DVA;
                end
                ST_DVA:
                begin
                    dva_reg   <= dva_res.val;
                    sat_reg   <= sat_reg | dva_res.sat;
                    state_reg <= ST_SCL;
                end
                ST_SCL:
                begin
                    if (mul_done)
                    begin
                        s_reg     <= ms40.val;
                        sat_reg   <= sat_reg | ms40.sat;
                        state_reg <= ST_FK;
                    end
                end
                ST_FK:
                begin
                    if (mul_done)
                    begin
                        delta_reg[k_reg] <= (dva_reg[63] != dneg_reg[k_reg]) ?
                                            (48'd0 - fcap) : fcap;
                        sat_reg <= sat_reg | fsat_k;
                        k_reg   <= k_reg + 2'd1;
                        if (k_reg == 2'd2)
                        begin
                            k_reg     <= '0;
                            state_reg <= ST_FRA;
                        end
                    end
                end
                ST_FRA:      state_reg <= ST_FUA;
                ST_FUA:
                begin
                    sat_reg   <= sat_reg | fsat;
                    state_reg <= ST_FRB;
                end
                ST_FRB:      state_reg <= ST_FUB;
                ST_FUB:
                begin
                    sat_reg   <= sat_reg | fsat;
                    state_reg <= ST_TOT;
                end
                ST_TOT:
                begin
                    ct_reg    <= ct_res.val;
                    vt_reg    <= vt_res.val;
                    sat_reg   <= sat_reg | ct_res.sat | vt_res.sat;
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // load the result register once it is free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        if (cmd_reg == CMD_ENERGY)
                        begin
                            m_tdata_reg <= {7'd0, sat_reg, vt_reg, ct_reg,
                                            144'd0};
                            ct_reg  <= '0;
                            vt_reg  <= '0;
                            sat_reg <= 1'b0;
                        end
                        else
                        begin
                            m_tdata_reg <= {7'd0, sat_reg, 128'd0,
                                            resf_reg[2], resf_reg[1], resf_reg[0]};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
